// ===== sv/lic_pkg.sv =====
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types and constants for the logical immediate classifier pipeline.
// ----------------------------------------------------------------------------
package lic_pkg;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned HalfW      = 32;
  localparam int unsigned ChunkW     = 16;
  localparam int unsigned NumChunks  = 4;
  // candidate element sizes 2, 4, 8, 16, 32 (index k means size 2 << k)
  localparam int unsigned NumPeriods = 5;
  localparam int unsigned CountW     = 3;

  // input beat
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_32bit;
  } in_t;

  // output beat
  typedef struct packed {
    logic is_bitmask_imm;
    logic is_move_wide_imm;
    logic prefer_movz;
  } out_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic [ValueW-1:0]    opnd;        // normalized operand, bit 0 clear
    logic                 trivial;     // all zeros or all ones
    logic                 move_wide;
    logic [NumChunks-1:0] chunk_zero;
    logic [NumChunks-1:0] chunk_ones;
  } prep_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic [ValueW-1:0]     rise;       // start bit of every run of ones
    logic [NumPeriods-1:0] periodic;   // operand repeats with element size
    logic                  trivial;
    logic                  move_wide;
    logic [NumChunks-1:0]  chunk_zero;
    logic [NumChunks-1:0]  chunk_ones;
  } scan_t;

endpackage

// ===== sv/lic_prep.sv =====
// ----------------------------------------------------------------------------
// lic_prep
// First stage: pick the operand size, flag all-zero/all-one operands,
// normalize so bit 0 is clear, and decode the move-wide and chunk flags.
// ----------------------------------------------------------------------------
module lic_prep
  import lic_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output prep_t out_data_o
);

  logic  valid_q;
  prep_t data_q, data_d;

  // Accept whenever the register is empty or drains this cycle
  assign in_ready_o = !valid_q || out_ready_i;

  // Normalize the operand and decode chunk flags
  always_comb begin
    logic [HalfW-1:0]  low;
    logic [HalfW-1:0]  low_x;
    logic [ValueW-1:0] val;
    logic [ValueW-1:0] full_x;
    low    = in_data_i.value[HalfW-1:0];
    val    = in_data_i.value;
    low_x  = low[0] ? ~low : low;
    full_x = val[0] ? ~val : val;
    if (in_data_i.is_32bit) begin
      data_d.opnd      = {low_x, low_x};
      data_d.trivial   = (low == '0) || (low == '1);
      data_d.move_wide = (low[HalfW-1:ChunkW] == '0) || (low[ChunkW-1:0] == '0);
    end else begin
      data_d.opnd      = full_x;
      data_d.trivial   = (val == '0) || (val == '1);
      data_d.move_wide = (val[3*ChunkW-1:0] == '0)
                      || ({val[ValueW-1:3*ChunkW], val[2*ChunkW-1:0]} == '0)
                      || ({val[ValueW-1:2*ChunkW], val[ChunkW-1:0]} == '0)
                      || (val[ValueW-1:ChunkW] == '0);
    end
    for (int i = 0; i < NumChunks; i++) begin
      data_d.chunk_zero[i] = (val[ChunkW*i +: ChunkW] == '0);
      data_d.chunk_ones[i] = (val[ChunkW*i +: ChunkW] == '1);
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // A non-trivial operand is nonzero with bit 0 clear after normalizing
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.trivial |-> !data_q.opnd[0] && (data_q.opnd != '0))
    else $error("normalized operand malformed");

endmodule

// ===== sv/lic_scan.sv =====
// ----------------------------------------------------------------------------
// lic_scan
// Second stage: mark the start of each run of ones and test the operand
// for repetition at every candidate element size.
// ----------------------------------------------------------------------------
module lic_scan
  import lic_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  prep_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output scan_t out_data_o
);

  logic                  valid_q;
  scan_t                 data_q, data_d;
  logic [NumPeriods-1:0] periodic;

  assign in_ready_o = !valid_q || out_ready_i;

  // Compare the operand with itself shifted by each element size
  for (genvar k = 0; k < NumPeriods; k++) begin : g_period
    localparam int unsigned Size = 2 << k;
    assign periodic[k] =
      (in_data_i.opnd[ValueW-1:Size] == in_data_i.opnd[ValueW-1-Size:0]);
  end

  // Run starts: a one whose lower neighbor is zero
  always_comb begin
    data_d.rise       = in_data_i.opnd & ~{in_data_i.opnd[ValueW-2:0], 1'b0};
    data_d.periodic   = periodic;
    data_d.trivial    = in_data_i.trivial;
    data_d.move_wide  = in_data_i.move_wide;
    data_d.chunk_zero = in_data_i.chunk_zero;
    data_d.chunk_ones = in_data_i.chunk_ones;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Repeating at one size implies repeating at twice that size
  a_period_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (!data_q.periodic[0] || data_q.periodic[1])
             && (!data_q.periodic[1] || data_q.periodic[2])
             && (!data_q.periodic[2] || data_q.periodic[3])
             && (!data_q.periodic[3] || data_q.periodic[4]))
    else $error("periodicity flags inconsistent");

endmodule

// ===== sv/lic_decide.sv =====
// ----------------------------------------------------------------------------
// lic_decide
// Third stage: require a single run per repeated element, merge the
// flags and compare zero and all-one chunk counts. Holds the output beat.
// ----------------------------------------------------------------------------
module lic_decide
  import lic_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  scan_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  logic                  valid_q;
  out_t                  data_q, data_d;
  logic [NumPeriods-1:0] elem_single;
  logic                  whole_single;
  logic [CountW-1:0]     zero_cnt;
  logic [CountW-1:0]     ones_cnt;

  // True when exactly one bit is set
  function automatic logic one_hot64(logic [ValueW-1:0] x);
    return (x != '0) && ((x & (x - ValueW'(1))) == '0);
  endfunction

  assign in_ready_o = !valid_q || out_ready_i;

  // One run start inside the lowest element of each size
  for (genvar k = 0; k < NumPeriods; k++) begin : g_elem
    localparam int unsigned Size = 2 << k;
    localparam logic [ValueW-1:0] Mask = (ValueW'(1) << Size) - ValueW'(1);
    assign elem_single[k] = one_hot64(in_data_i.rise & Mask);
  end

  assign whole_single = one_hot64(in_data_i.rise);

  // Count all-zero and all-one chunks
  always_comb begin
    zero_cnt = '0;
    ones_cnt = '0;
    for (int i = 0; i < NumChunks; i++) begin
      zero_cnt = zero_cnt + CountW'(in_data_i.chunk_zero[i]);
      ones_cnt = ones_cnt + CountW'(in_data_i.chunk_ones[i]);
    end
  end

  always_comb begin
    data_d.is_bitmask_imm   = !in_data_i.trivial
                           && (whole_single || |(in_data_i.periodic & elem_single));
    data_d.is_move_wide_imm = in_data_i.move_wide;
    data_d.prefer_movz      = (zero_cnt >= ones_cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/logical_immediate_classifier.sv =====
// ----------------------------------------------------------------------------
// logical_immediate_classifier
// Classifies a 64-bit constant as bitmask immediate, single move-wide
// immediate, and MOVZ-versus-MOVN preference, in a three-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  beat
//  in       sink       in_valid_i / in_ready_o    in_data_i  (value, is_32bit)
//  out      source     out_valid_o / out_ready_i  out_data_o (three flags)
//
//  One beat per cycle sustained while the output is not stalled; each beat is
//  registered in prep, scan and decide (the decide register is the output register).
//  Reset clears the three stage valid bits only; payload registers are not reset.
//  A stall at the output backs up one stage at a time; each stage keeps
//  accepting while the stage ahead of it drains or holds a bubble.
// ----------------------------------------------------------------------------
module logical_immediate_classifier
  import lic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic  prep_valid, prep_ready;
  prep_t prep_data;
  logic  scan_valid, scan_ready;
  scan_t scan_data;

  lic_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_data_o  (prep_data)
  );

  lic_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_data_i   (prep_data),
    .out_valid_o (scan_valid),
    .out_ready_i (scan_ready),
    .out_data_o  (scan_data)
  );

  lic_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scan_valid),
    .in_ready_o  (scan_ready),
    .in_data_i   (scan_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Back-pressure reaches the input only when every stage is full and stalled
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> prep_valid && scan_valid && out_valid_o && !out_ready_i)
    else $error("input stalled with a bubble in the pipeline");

  // An accepted beat lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> prep_valid)
    else $error("accepted beat lost at entry");

  // A beat leaving the first stage lands in the second
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prep_valid && prep_ready |=> scan_valid)
    else $error("beat lost between prep and scan");

endmodule

// ===== tb/logical_immediate_classifier_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// logical_immediate_classifier_test
// Drives constants through the classifier with random idle gaps on both
// channels and checks each output beat, in order, against a flag predictor
// written here. A directed table of edge values runs first, then about 1500
// generated constants, most of them built as bitmask or move-wide candidates.
// ----------------------------------------------------------------------------
module logical_immediate_classifier_test;
  import lic_pkg::*;

  localparam int unsigned RandItems   = 1500;
  localparam int unsigned PhaseItems  = RandItems / 3;
  localparam int unsigned HoldCycles  = 200;
  // longest legal quiet stretch is the hold above plus a few random stalls
  localparam int unsigned StuckLimit  = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned ShowLimit   = 10;

  typedef enum logic [2:0] {
    GenBitmask,
    GenBitmaskFlip,
    GenMoveWide,
    GenChunks,
    GenRaw
  } gen_kind_e;

  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t want;
  } row_t;

  typedef struct packed {
    in_t  beat;
    out_t flags;
  } due_t;

  // edge values; want is only meaningful where typed is set
  localparam int unsigned NumRows = 26;
  localparam row_t DirRows [NumRows] = '{
    '{'{64'h0000_0000_0000_0000, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_0000_0000_0000, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{64'hFFFF_FFFF_0000_0000, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{64'h0000_0000_FFFF_FFFF, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_0000_0000_FFFF, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{64'h8000_0000_0000_0000, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{64'h5555_5555_5555_5555, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b1}},
    '{'{64'h0000_0000_0000_0001, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{64'h0F0F_0F0F_0F0F_0F0F, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h00FF_00FF_00FF_00FF, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_FFFF_0000_FFFF, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h3333_3333_3333_3333, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h6666_6666_6666_6666, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h8000_0000_0000_0001, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_0000_0000_0005, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0001_0001_0001_0000, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_1234_0000_0000, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'hFFFF_0000_FFFF_FFFF, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'hFFFF_FFFF_FFFF_1234, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h7FFF_FFFF_FFFF_FFFE, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'hDEAD_BEEF_5555_5555, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h1234_5678_8000_0001, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'h0000_0000_F000_0000, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{64'hFFFF_FFFF_0000_FFFE, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}}
  };

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  due_t        flags_due_q[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  logic        hold_req       = 1'b0;
  int unsigned err_count      = 0;
  int unsigned beats_in       = 0;
  int unsigned narrow_beats   = 0;
  int unsigned bitmask_hits   = 0;
  int unsigned move_wide_hits = 0;
  int unsigned stuck_cycles   = 0;

  logical_immediate_classifier DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned low_zeros(logic [ValueW-1:0] x);
    int unsigned n;
    n = 0;
    while (n < ValueW && !x[n]) n++;
    return n;
  endfunction

  function automatic logic bitmask_ok(logic [ValueW-1:0] v, logic narrow);
    logic [ValueW-1:0] t;
    int unsigned       span;
    // all zeros and all ones of the operand are not encodable
    if (narrow) begin
      v = {32'd0, v[HalfW-1:0]};
      if (v[HalfW-1:0] == '0 || v[HalfW-1:0] == '1) return 1'b0;
    end else if (v == '0 || v == '1) begin
      return 1'b0;
    end
    // normalize to bit 0 clear, then widen a 32-bit operand by repetition
    if (v[0]) v = ~v;
    if (narrow) v = {v[HalfW-1:0], v[HalfW-1:0]};
    // clear the lowest run, drop its carry bit; nothing left means one run
    t = v + (v & (~v + 64'd1));
    t = t & (t - 64'd1);
    if (t == '0) return 1'b1;
    span = low_zeros(t) - low_zeros(v);
    if (!(span inside {2, 4, 8, 16, 32})) return 1'b0;
    // a value that repeats with the run spacing is unchanged by that rotation
    return ((v << span) | (v >> (ValueW - span))) == v;
  endfunction

  function automatic logic move_wide_ok(logic [ValueW-1:0] v, logic narrow);
    int unsigned busy;
    busy = 0;
    for (int i = 0; i < (narrow ? 2 : NumChunks); i++) begin
      if (v[ChunkW*i +: ChunkW] != '0) busy++;
    end
    return busy <= 1;
  endfunction

  function automatic logic movz_ok(logic [ValueW-1:0] v);
    int unsigned zeros;
    int unsigned ones;
    zeros = 0;
    ones  = 0;
    for (int i = 0; i < NumChunks; i++) begin
      if (v[ChunkW*i +: ChunkW] == '0) zeros++;
      else if (v[ChunkW*i +: ChunkW] == '1) ones++;
    end
    return zeros >= ones;
  endfunction

  function automatic out_t classify_constant(in_t beat);
    out_t flags;
    flags.is_bitmask_imm   = bitmask_ok(beat.value, beat.is_32bit);
    flags.is_move_wide_imm = move_wide_ok(beat.value, beat.is_32bit);
    flags.prefer_movz      = movz_ok(beat.value);
    return flags;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic gen_kind_e pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return GenBitmask;
    if (roll < 50) return GenBitmaskFlip;
    if (roll < 65) return GenMoveWide;
    if (roll < 85) return GenChunks;
    return GenRaw;
  endfunction

  function automatic in_t make_constant(gen_kind_e kind);
    in_t               beat;
    logic [ValueW-1:0] elem;
    logic [ValueW-1:0] word;
    logic [HalfW-1:0]  upper;
    int unsigned       size;
    int unsigned       run;
    int unsigned       rot;
    beat.is_32bit = 1'($urandom_range(0, 1));
    upper         = $urandom();
    word          = '0;
    case (kind)
      GenBitmask, GenBitmaskFlip: begin
        // rotated run of ones inside an element, repeated over the word
        size = 1 << $urandom_range(1, beat.is_32bit ? 5 : 6);
        run  = $urandom_range(1, size - 1);
        rot  = $urandom_range(0, size - 1);
        elem = (64'd1 << run) - 64'd1;
        if (rot != 0) elem = (elem >> rot) | (elem << (size - rot));
        if (size < ValueW) elem &= (64'd1 << size) - 64'd1;
        for (int i = 0; i < ValueW; i += size) word |= elem << i;
        if (kind == GenBitmaskFlip) begin
          word[$urandom_range(0, beat.is_32bit ? HalfW - 1 : ValueW - 1)] ^= 1'b1;
        end
      end
      GenMoveWide: begin
        word = 64'($urandom_range(0, 16'hFFFF));
        word = word << (ChunkW * $urandom_range(0, beat.is_32bit ? 1 : 3));
      end
      GenChunks: begin
        for (int i = 0; i < NumChunks; i++) begin
          case ($urandom_range(0, 2))
            0:       word[ChunkW*i +: ChunkW] = '0;
            1:       word[ChunkW*i +: ChunkW] = '1;
            default: word[ChunkW*i +: ChunkW] = ChunkW'($urandom());
          endcase
        end
      end
      default: begin
        word = {upper, 32'($urandom())};
      end
    endcase
    // a 32-bit operand carries upper bits that the bitmask and move-wide checks must ignore
    beat.value = (beat.is_32bit && kind != GenChunks) ? {upper, word[HalfW-1:0]} : word;
    return beat;
  endfunction

  // offer one beat, idling first at random; record the expected flags on accept
  task automatic send_constant(in_t beat, logic typed, out_t want);
    due_t entry;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    entry.beat  = beat;
    entry.flags = typed ? want : classify_constant(beat);
    flags_due_q.push_back(entry);
    beats_in++;
    if (beat.is_32bit) narrow_beats++;
  endtask

  // receiver: random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : check_out
    due_t entry;
    if (out_valid_o && out_ready_i) begin
      bitmask_hits   += out_data_o.is_bitmask_imm;
      move_wide_hits += out_data_o.is_move_wide_imm;
      if (flags_due_q.size() == 0) begin
        err_count++;
        if (err_count <= ShowLimit) begin
          $display("unexpected output beat: flags %b", out_data_o);
        end
      end else begin
        entry = flags_due_q.pop_front();
        if (entry.flags.is_bitmask_imm != out_data_o.is_bitmask_imm ||
            entry.flags.is_move_wide_imm != out_data_o.is_move_wide_imm ||
            entry.flags.prefer_movz != out_data_o.prefer_movz) begin
          err_count++;
          if (err_count <= ShowLimit) begin
            $display("mismatch for %h (32-bit %b): bitmask %b/%b move_wide %b/%b movz %b/%b",
                     entry.beat.value, entry.beat.is_32bit,
                     entry.flags.is_bitmask_imm, out_data_o.is_bitmask_imm,
                     entry.flags.is_move_wide_imm, out_data_o.is_move_wide_imm,
                     entry.flags.prefer_movz, out_data_o.prefer_movz);
            $display("  (expected/actual)");
          end
        end
      end
    end
  end

  // watchdog: end the run if no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles <= 0;
    end else if (rst_ni) begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("watchdog: no beat moved for %0d cycles", stuck_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed edge values
    foreach (DirRows[r]) begin
      send_constant(DirRows[r].beat, DirRows[r].typed, DirRows[r].want);
    end

    // generated constants: slow receiver, slow sender, then full rate with one long receiver hold
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 34;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 34;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req      = 1'b1;
        end
      endcase
      repeat (PhaseItems) send_constant(make_constant(pick_kind()), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // drain, then give any stray beat time to show up
    while (flags_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("classified %0d constants (%0d as 32-bit operands) with idling on both sides",
             beats_in, narrow_beats);
    $display("saw %0d bitmask and %0d single move-wide immediates", bitmask_hits,
             move_wide_hits);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
